// ===== hw/rtl/sfb_pkg.sv =====
package sfb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MSG_KIND        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTE_ID         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_ENABLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE_BYTE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_BYTE      = 3'd4;

    localparam logic [7:0]  RST_MSG_KIND        = 8'd4;
    localparam logic [15:0] RST_MOTE_ID         = 16'd10;
    localparam logic        RST_SYNC_ENABLE     = 1'b1;
    localparam logic [7:0]  RST_FRAME_TYPE_BYTE = 8'd66;
    localparam logic [7:0]  RST_GROUP_BYTE      = 8'd125;

    localparam logic [7:0] MT_INT_A   = 8'd4;
    localparam logic [7:0] MT_ARRAY   = 8'd5;
    localparam logic [7:0] MT_INT_B   = 8'd6;
    localparam logic [7:0] MT_VEHICLE = 8'd8;

    localparam logic [7:0] SYNC_BYTE  = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] DEST_BYTE  = 8'hFF;
    localparam logic [7:0] CHECK_BYTE = 8'h00;
    localparam logic [7:0] FIXED_PLEN_WORD    = 8'd4;
    localparam logic [7:0] FIXED_PLEN_VEHICLE = 8'd3;

    typedef struct packed {
        logic [15:0] value;
        logic        last_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       overflow;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  msg_kind;
        logic [15:0] mote_id;
        logic        sync_enable;
        logic [7:0]  frame_type_byte;
        logic [7:0]  group_byte;
    } cfg_t;

endpackage

// ===== hw/rtl/sfb_store.sv =====
module sfb_store #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/sfb_framer.sv =====
module sfb_framer
    import sfb_pkg::*;
#(
    parameter int MAX_VALUES = 8,
    parameter int AW         = 3,
    parameter int CW         = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  in_item_t      item,
    output logic          busy,
    input  cfg_t          cfg,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [15:0]   wr_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic [15:0]   rd_data,
    output logic          result_valid,
    output out_item_t     result
);

    typedef enum logic [3:0] {
        S_IDLE, S_SYNC0, S_FTYPE, S_DST0, S_DST1, S_MTYPE, S_GROUP, S_PLEN,
        S_WLO, S_WHI, S_MLO, S_MHI, S_CK0, S_CK1, S_SYNC1
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           ovf_reg, ovf_next;
    logic [AW-1:0]  widx_reg, widx_next;
    logic [7:0]     plen_reg, plen_next;
    logic           pend_reg, pend_next;
    logic [7:0]     pend_byte_reg, pend_byte_next;
    logic           result_valid_reg, result_valid_next;
    out_item_t      result_reg, result_next;

    logic           accept;
    logic           has_room;
    logic [CW-1:0]  cnt_acc;
    logic           ovf_acc;
    logic           known_type;
    logic [7:0]     cur;
    logic           stuffable;
    logic           esc;
    logic           last_word;
    state_t         final_st;

    assign busy     = (state_reg != S_IDLE) || pend_reg;
    assign accept   = start && !busy;
    assign has_room = cnt_reg < CW'(MAX_VALUES);
    assign cnt_acc  = has_room ? cnt_reg + CW'(1) : cnt_reg;
    assign ovf_acc  = ovf_reg || !has_room;

    assign wr_en   = accept && has_room;
    assign wr_addr = cnt_reg[AW-1:0];
    assign wr_data = item.value;

    assign known_type = (cfg.msg_kind == MT_INT_A) || (cfg.msg_kind == MT_INT_B)
                     || (cfg.msg_kind == MT_ARRAY) || (cfg.msg_kind == MT_VEHICLE);
    assign last_word  = (CW'(widx_reg) + CW'(1)) == cnt_reg;
    assign final_st   = cfg.sync_enable ? S_SYNC1 : S_CK1;

    always_comb
    begin
        case (state_reg)
            S_SYNC0: cur = SYNC_BYTE;
            S_FTYPE: cur = cfg.frame_type_byte;
            S_DST0:  cur = DEST_BYTE;
            S_DST1:  cur = DEST_BYTE;
            S_MTYPE: cur = cfg.msg_kind;
            S_GROUP: cur = cfg.group_byte;
            S_PLEN:  cur = plen_reg;
            S_WLO:   cur = rd_data[7:0];
            S_WHI:   cur = rd_data[15:8];
            S_MLO:   cur = cfg.mote_id[7:0];
            S_MHI:   cur = cfg.mote_id[15:8];
            S_CK0:   cur = CHECK_BYTE;
            S_CK1:   cur = CHECK_BYTE;
            S_SYNC1: cur = SYNC_BYTE;
            default: cur = CHECK_BYTE;
        endcase
    end

    assign stuffable = (state_reg != S_SYNC0) && (state_reg != S_SYNC1);
    assign esc       = stuffable && ((cur == SYNC_BYTE) || (cur == ESC_BYTE));

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        ovf_next          = ovf_reg;
        widx_next         = widx_reg;
        plen_next         = plen_reg;
        pend_next         = 1'b0;
        pend_byte_next    = pend_byte_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        rd_en             = 1'b0;
        rd_addr           = widx_reg;

        if (accept)
        begin
            cnt_next = cnt_acc;
            ovf_next = ovf_acc;
            if (item.last_value)
            begin
                if (known_type)
                begin
                    state_next = cfg.sync_enable ? S_SYNC0 : S_FTYPE;
                    if (cfg.msg_kind == MT_ARRAY)
                    begin
                        plen_next = 8'({cnt_acc, 1'b0}) + 8'd2;
                    end
                    else if (cfg.msg_kind == MT_VEHICLE)
                    begin
                        plen_next = FIXED_PLEN_VEHICLE;
                    end
                    else
                    begin
                        plen_next = FIXED_PLEN_WORD;
                    end
                end
                else
                begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
            end
        end
        else if (pend_reg)
        begin
            // second half of an escape pair; the sequencer holds
            result_valid_next    = 1'b1;
            result_next.out_byte = pend_byte_reg;
            result_next.frame_end = 1'b0;
            result_next.overflow = ovf_reg;
        end
        else if (state_reg != S_IDLE)
        begin
            result_valid_next     = 1'b1;
            result_next.out_byte  = esc ? ESC_BYTE : cur;
            result_next.frame_end = (state_reg == final_st);
            result_next.overflow  = ovf_reg;
            pend_next             = esc;
            pend_byte_next        = cur ^ ESC_XOR;

            case (state_reg)
                S_SYNC0: state_next = S_FTYPE;
                S_FTYPE: state_next = S_DST0;
                S_DST0:  state_next = S_DST1;
                S_DST1:  state_next = S_MTYPE;
                S_MTYPE: state_next = S_GROUP;
                S_GROUP: state_next = S_PLEN;
                S_PLEN:
                begin
                    // fetch the first stored word while the length byte goes out, so it is ready in S_WLO
                    state_next = S_WLO;
                    widx_next  = '0;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                end
                S_WLO:   state_next = (cfg.msg_kind == MT_VEHICLE) ? S_MLO : S_WHI;
                S_WHI:
                begin
                    if ((cfg.msg_kind == MT_ARRAY) && !last_word)
                    begin
                        state_next = S_WLO;
                        widx_next  = widx_reg + AW'(1);
                        rd_en      = 1'b1;
                        rd_addr    = widx_reg + AW'(1);
                    end
                    else
                    begin
                        state_next = S_MLO;
                    end
                end
                S_MLO:   state_next = S_MHI;
                S_MHI:   state_next = S_CK0;
                S_CK0:   state_next = S_CK1;
                S_CK1:   state_next = cfg.sync_enable ? S_SYNC1 : S_IDLE;
                S_SYNC1: state_next = S_IDLE;
                default: state_next = S_IDLE;
            endcase

            if (state_reg == final_st)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            ovf_reg          <= 1'b0;
            widx_reg         <= '0;
            plen_reg         <= '0;
            pend_reg         <= 1'b0;
            pend_byte_reg    <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            ovf_reg          <= ovf_next;
            widx_reg         <= widx_next;
            plen_reg         <= plen_next;
            pend_reg         <= pend_next;
            pend_byte_reg    <= pend_byte_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hw/rtl/serial_frame_builder_with_byte_stuffing_unit.sv =====
// Values load one per cycle while busy is low; a value that is not last gives no output.
// Busy rises at the edge that takes the last value of a known message kind, and the frame
// leaves one byte per cycle; that transfer sets the sequencer state, from which the first
// byte is registered onto the result ports. Each stuffed byte is sent as an escape pair.
// Reset clears the value count, the overflow flag and the sequencer and loads the register
// defaults; the value store is not cleared. The receiver cannot stall the byte stream.
module serial_frame_builder_with_byte_stuffing_unit
    import sfb_pkg::*;
#(
    parameter int MAX_VALUES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_item_t              item,
    output logic                  result_valid,
    output out_item_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CW = $clog2(MAX_VALUES + 1);

    cfg_t           cfg_reg;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [15:0]    wr_data;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [15:0]    rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.msg_kind        <= RST_MSG_KIND;
            cfg_reg.mote_id         <= RST_MOTE_ID;
            cfg_reg.sync_enable     <= RST_SYNC_ENABLE;
            cfg_reg.frame_type_byte <= RST_FRAME_TYPE_BYTE;
            cfg_reg.group_byte      <= RST_GROUP_BYTE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MSG_KIND:        cfg_reg.msg_kind        <= cfg_data[7:0];
                REG_MOTE_ID:         cfg_reg.mote_id         <= cfg_data;
                REG_SYNC_ENABLE:     cfg_reg.sync_enable     <= cfg_data[0];
                REG_FRAME_TYPE_BYTE: cfg_reg.frame_type_byte <= cfg_data[7:0];
                REG_GROUP_BYTE:      cfg_reg.group_byte      <= cfg_data[7:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    sfb_store #(
        .DEPTH (MAX_VALUES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sfb_framer #(
        .MAX_VALUES (MAX_VALUES),
        .AW         (AW),
        .CW         (CW)
    ) u_framer (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .cfg          (cfg_reg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
